// ===== rtl/vplc_pkg.sv =====
// Package for the verified pair cache: item and result types, opcodes and
// default sizes. Used by the channel interfaces and by the cache unit.
package vplc_pkg;

    // Default sizes handed to the top-level parameters
    localparam int CACHE_ENTRIES_DEF = 32;
    localparam int KEY_BITS_DEF      = 64;

    // Fixed field widths
    localparam int FIELD_KEY_BITS = 64;
    localparam int CFG_BITS       = 6;
    localparam int OUT_CNT_BITS   = 6;

    // Capacity limit after reset
    localparam logic [CFG_BITS-1:0] LIMIT_RESET = 6'd30;

    // Opcodes
    localparam logic OP_QUERY = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic                      opcode;
        logic [FIELD_KEY_BITS-1:0] subject_key;
        logic [FIELD_KEY_BITS-1:0] issuer_key;
        logic [3:0]                subject_type;
        logic                      flush_all;
        logic                      signature_ok;
    } t_item;

    typedef struct packed {
        logic                    trusted;
        logic                    cache_hit;
        logic                    evicted;
        logic [OUT_CNT_BITS-1:0] entries_used;
        logic [OUT_CNT_BITS-1:0] flushed_count;
    } t_result;

endpackage

// ===== rtl/vplc_ifs.sv =====
// Valid/ready channel interfaces of the verified pair cache: query item,
// result item and capacity-limit write. Depends on vplc_pkg.
interface vplc_item_if;
    import vplc_pkg::*;
    logic  valid;
    logic  ready;
    t_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface vplc_res_if;
    import vplc_pkg::*;
    logic    valid;
    logic    ready;
    t_result data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface vplc_cfg_if;
    import vplc_pkg::*;
    logic                valid;
    logic                ready;
    logic [CFG_BITS-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/verified_pair_lru_cache_unit.sv =====
// Verified pair cache with least recently used replacement, top level.
// Depends on vplc_pkg and the channel interfaces in vplc_ifs.sv.
//
// Fully associative cache of (subject key, issuer key) pairs. One item is
// handled at a time; i_item.ready is high only while the unit is idle. Every
// item is served by walking all CACHE_ENTRIES entries through one shared
// compare unit, one entry per cycle behind a registered memory read. A hit
// then refreshes its stamp in S_TOUCH; a flush or a miss without a good
// signature goes straight to the result; an insert passes S_DECIDE and
// S_INSERT, evicting the victim found during the first walk if needed, and
// walks again for each further eviction (only when the limit was lowered
// below the fill level). The result is then held until o_res.ready. Limit
// writes are always taken.
module verified_pair_lru_cache_unit #(
    parameter int CACHE_ENTRIES = vplc_pkg::CACHE_ENTRIES_DEF,
    parameter int KEY_BITS      = vplc_pkg::KEY_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    vplc_item_if.sink           i_item,
    vplc_res_if.source          o_res,
    vplc_cfg_if.sink            i_cfg
);
    import vplc_pkg::*;

    localparam int IW = $clog2(CACHE_ENTRIES);
    localparam int CW = $clog2(CACHE_ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_TOUCH,
        S_INSERT,
        S_RESP
    } t_state;

    typedef enum logic [1:0] {
        M_MATCH,
        M_VICTIM,
        M_FLUSH
    } t_mode;

    // Entry storage
    logic [KEY_BITS-1:0] mem_subject [CACHE_ENTRIES];
    logic [KEY_BITS-1:0] mem_issuer  [CACHE_ENTRIES];
    logic [3:0]          mem_type    [CACHE_ENTRIES];
    logic [63:0]         mem_stamp   [CACHE_ENTRIES];

    logic [KEY_BITS-1:0] r_rd_subject;
    logic [KEY_BITS-1:0] r_rd_issuer;
    logic [3:0]          r_rd_type;
    logic [63:0]         r_rd_stamp;

    // Control and captured item
    t_state               r_state;
    t_mode                r_mode;
    logic [CACHE_ENTRIES-1:0] r_valid;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_idx;
    logic [IW-1:0]        r_cmp_idx;
    logic                 r_cmp_vld;
    logic [CFG_BITS-1:0]  r_limit;
    logic [63:0]          r_stamp;

    logic [KEY_BITS-1:0]  r_skey;
    logic [KEY_BITS-1:0]  r_ikey;
    logic [3:0]           r_stype;
    logic                 r_all;
    logic                 r_sig;

    logic                 r_hit;
    logic [IW-1:0]        r_hit_idx;
    logic                 r_vic_found;
    logic [IW-1:0]        r_vic_idx;
    logic [63:0]          r_vic_stamp;
    logic                 r_free_found;
    logic [IW-1:0]        r_free_idx;

    logic                 r_trusted;
    logic                 r_evicted;
    logic [CW-1:0]        r_flushed;

    // Shared compare unit and helpers
    logic                 ent_v;
    logic                 key_eq;
    logic                 stamp_lt;
    logic                 type_hit;
    logic                 scan_end;
    logic                 walk_done;
    logic [CW-1:0]        lim_eff;
    logic                 key_we;
    logic                 stamp_we;
    logic [IW-1:0]        wr_idx;
    logic [63:0]          stamp_next;
    logic [CW+OUT_CNT_BITS-1:0] cnt_ext;
    logic [CW+OUT_CNT_BITS-1:0] flush_ext;

    assign ent_v     = r_valid[r_cmp_idx];
    assign key_eq    = (r_rd_subject == r_skey) && (r_rd_issuer == r_ikey);
    assign stamp_lt  = r_rd_stamp < r_vic_stamp;
    assign type_hit  = r_all || (r_rd_type == r_stype);
    assign scan_end  = (r_idx == CW'(CACHE_ENTRIES));
    assign walk_done = scan_end && !r_cmp_vld;
    assign stamp_next = r_stamp + 64'd1;

    // Clamp the limit into 1 .. CACHE_ENTRIES
    always_comb begin
        if (r_limit == '0) begin
            lim_eff = CW'(1);
        end else if (int'(r_limit) > CACHE_ENTRIES) begin
            lim_eff = CW'(CACHE_ENTRIES);
        end else begin
            lim_eff = CW'(r_limit);
        end
    end

    // Write port selection
    assign key_we   = (r_state == S_INSERT);
    assign stamp_we = (r_state == S_INSERT) || (r_state == S_TOUCH);
    assign wr_idx   = (r_state == S_INSERT) ? r_free_idx : r_hit_idx;

    // Storage: one write port, one registered read port driven by the walk
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            mem_subject[wr_idx] <= r_skey;
            mem_issuer[wr_idx]  <= r_ikey;
            mem_type[wr_idx]    <= r_stype;
        end
        if (stamp_we) begin
            mem_stamp[wr_idx] <= stamp_next;
        end
        r_rd_subject <= mem_subject[r_idx[IW-1:0]];
        r_rd_issuer  <= mem_issuer[r_idx[IW-1:0]];
        r_rd_type    <= mem_type[r_idx[IW-1:0]];
        r_rd_stamp   <= mem_stamp[r_idx[IW-1:0]];
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mode       <= M_MATCH;
            r_valid      <= '0;
            r_count      <= '0;
            r_idx        <= '0;
            r_cmp_vld    <= 1'b0;
            r_limit      <= LIMIT_RESET;
            r_stamp      <= '0;
            r_hit        <= 1'b0;
            r_vic_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_trusted    <= 1'b0;
            r_evicted    <= 1'b0;
            r_flushed    <= '0;
        end else begin
            // Take limit writes at any time
            if (i_cfg.valid) begin
                r_limit <= i_cfg.data;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_item.valid) begin
                        r_skey       <= i_item.data.subject_key[KEY_BITS-1:0];
                        r_ikey       <= i_item.data.issuer_key[KEY_BITS-1:0];
                        r_stype      <= i_item.data.subject_type;
                        r_all        <= i_item.data.flush_all;
                        r_sig        <= i_item.data.signature_ok;
                        r_mode       <= (i_item.data.opcode == OP_FLUSH) ? M_FLUSH
                                                                         : M_MATCH;
                        r_idx        <= '0;
                        r_cmp_vld    <= 1'b0;
                        r_hit        <= 1'b0;
                        r_vic_found  <= 1'b0;
                        r_free_found <= 1'b0;
                        r_trusted    <= 1'b0;
                        r_evicted    <= 1'b0;
                        r_flushed    <= '0;
                        r_state      <= S_SCAN;
                    end
                end

                S_SCAN: begin
                    // Advance the read address
                    r_cmp_vld <= !scan_end;
                    r_cmp_idx <= r_idx[IW-1:0];
                    if (!scan_end) begin
                        r_idx <= r_idx + CW'(1);
                    end

                    // Compare the entry read last cycle
                    if (r_cmp_vld) begin
                        if (r_mode == M_FLUSH) begin
                            if (ent_v && type_hit) begin
                                r_valid[r_cmp_idx] <= 1'b0;
                                r_count            <= r_count - CW'(1);
                                r_flushed          <= r_flushed + CW'(1);
                            end
                        end else begin
                            if (ent_v && (!r_vic_found || stamp_lt)) begin
                                r_vic_found <= 1'b1;
                                r_vic_idx   <= r_cmp_idx;
                                r_vic_stamp <= r_rd_stamp;
                            end
                            if (r_mode == M_MATCH) begin
                                if (ent_v && key_eq && !r_hit) begin
                                    r_hit     <= 1'b1;
                                    r_hit_idx <= r_cmp_idx;
                                end
                                if (!ent_v && !r_free_found) begin
                                    r_free_found <= 1'b1;
                                    r_free_idx   <= r_cmp_idx;
                                end
                            end
                        end
                    end

                    // Walk finished: pick the next step
                    if (walk_done) begin
                        case (r_mode)
                            M_FLUSH: r_state <= S_RESP;
                            M_VICTIM: r_state <= S_DECIDE;
                            default: begin
                                if (r_hit) begin
                                    r_state <= S_TOUCH;
                                end else if (r_sig) begin
                                    r_state <= S_DECIDE;
                                end else begin
                                    r_state <= S_RESP;
                                end
                            end
                        endcase
                    end
                end

                S_DECIDE: begin
                    if (r_count < lim_eff) begin
                        r_state <= S_INSERT;
                    end else if (r_vic_found) begin
                        // Drop the oldest pair; its slot becomes a free candidate
                        r_valid[r_vic_idx] <= 1'b0;
                        r_count            <= r_count - CW'(1);
                        r_evicted          <= 1'b1;
                        r_vic_found        <= 1'b0;
                        if (!r_free_found || (r_vic_idx < r_free_idx)) begin
                            r_free_found <= 1'b1;
                            r_free_idx   <= r_vic_idx;
                        end
                    end else begin
                        // Still over the limit: walk again for the next victim
                        r_mode    <= M_VICTIM;
                        r_idx     <= '0;
                        r_cmp_vld <= 1'b0;
                        r_state   <= S_SCAN;
                    end
                end

                S_TOUCH: begin
                    r_stamp   <= stamp_next;
                    r_trusted <= 1'b1;
                    r_state   <= S_RESP;
                end

                S_INSERT: begin
                    r_valid[r_free_idx] <= 1'b1;
                    r_count             <= r_count + CW'(1);
                    r_stamp             <= stamp_next;
                    r_trusted           <= 1'b1;
                    r_state             <= S_RESP;
                end

                S_RESP: begin
                    if (o_res.ready) begin
                        r_state <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Handshakes and result item
    assign i_item.ready = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign o_res.valid  = (r_state == S_RESP);

    assign cnt_ext   = {{OUT_CNT_BITS{1'b0}}, r_count};
    assign flush_ext = {{OUT_CNT_BITS{1'b0}}, r_flushed};

    assign o_res.data.trusted       = r_trusted;
    assign o_res.data.cache_hit     = r_hit && (r_mode == M_MATCH);
    assign o_res.data.evicted       = r_evicted;
    assign o_res.data.entries_used  = cnt_ext[OUT_CNT_BITS-1:0];
    assign o_res.data.flushed_count = flush_ext[OUT_CNT_BITS-1:0];

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for the verified pair cache unit: directed and random query and
// flush items, checked against a predictor of the cache held in the bench.
// Depends on vplc_pkg, the channel interfaces and verified_pair_lru_cache_unit.
module tb;
    import vplc_pkg::*;

    localparam int SLOTS = CACHE_ENTRIES_DEF;
    localparam logic [FIELD_KEY_BITS-1:0] KEY_MASK = {FIELD_KEY_BITS{1'b1}} >>
                                                     (FIELD_KEY_BITS - KEY_BITS_DEF);
    localparam int POOL_PAIRS     = 48;
    localparam int POOL_SUBJECTS  = 20;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 118;
    localparam int MAX_WAIT       = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int REPORT_CAP     = 50;

    logic clk = 1'b0;
    logic rst_n;

    vplc_item_if item_ch();
    vplc_res_if  res_ch();
    vplc_cfg_if  cfg_ch();

    verified_pair_lru_cache_unit DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_item  (item_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // Predicted cache contents
    bit                        held_valid   [SLOTS];
    logic [FIELD_KEY_BITS-1:0] held_subject [SLOTS];
    logic [FIELD_KEY_BITS-1:0] held_issuer  [SLOTS];
    logic [3:0]                held_type    [SLOTS];
    logic [63:0]               held_stamp   [SLOTS];
    logic [63:0]               use_clock;
    logic [CFG_BITS-1:0]       limit_shadow;

    // Pairs that random queries draw from, so that hits and evictions occur
    logic [FIELD_KEY_BITS-1:0] pool_subject [POOL_PAIRS];
    logic [FIELD_KEY_BITS-1:0] pool_issuer  [POOL_PAIRS];
    logic [3:0]                pool_type    [POOL_PAIRS];

    t_item   pending_items[$];
    t_result expected_results[$];

    bit send_gaps_on   = 1'b1;
    bit recv_stalls_on = 1'b1;
    int send_gap;
    int stall_left;
    int hold_left;
    int results_checked = 0;
    int error_count     = 0;
    int quiet_cycles;

    always #4 clk = ~clk;

    // Work out the result of one item and update the predicted cache
    function automatic t_result predict_lookup(input t_item it);
        t_result r;
        int held, found, victim, lim;
        logic [FIELD_KEY_BITS-1:0] skey, ikey;
        r = '0;
        held = 0;
        skey = it.subject_key & KEY_MASK;
        ikey = it.issuer_key & KEY_MASK;
        for (int i = 0; i < SLOTS; i++) held += held_valid[i];
        if (it.opcode == OP_FLUSH) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (held_valid[i] && (it.flush_all || held_type[i] == it.subject_type)) begin
                    held_valid[i] = 1'b0;
                    held--;
                    r.flushed_count = r.flushed_count + 1'b1;
                end
            end
        end else begin
            found = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (found < 0 && held_valid[i] && held_subject[i] == skey &&
                    held_issuer[i] == ikey)
                    found = i;
            end
            if (found >= 0) begin
                use_clock++;
                held_stamp[found] = use_clock;
                r.trusted   = 1'b1;
                r.cache_hit = 1'b1;
            end else if (it.signature_ok) begin
                lim = (limit_shadow == 0) ? 1 : ((limit_shadow > SLOTS) ? SLOTS : limit_shadow);
                // Drop least recently used pairs until the new one fits
                while (held >= lim) begin
                    victim = -1;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (held_valid[i] &&
                            (victim < 0 || held_stamp[i] < held_stamp[victim]))
                            victim = i;
                    end
                    held_valid[victim] = 1'b0;
                    held--;
                    r.evicted = 1'b1;
                end
                for (int i = 0; i < SLOTS; i++) begin
                    if (found < 0 && !held_valid[i]) found = i;
                end
                use_clock++;
                held_valid[found]   = 1'b1;
                held_subject[found] = skey;
                held_issuer[found]  = ikey;
                held_type[found]    = it.subject_type;
                held_stamp[found]   = use_clock;
                held++;
                r.trusted = 1'b1;
            end
        end
        r.entries_used = OUT_CNT_BITS'(held);
        return r;
    endfunction

    // Draw one random item: mostly pool pairs, some flushes and noise
    function automatic t_item random_item();
        t_item it;
        int pick, k;
        pick = $urandom_range(0, 99);
        k    = $urandom_range(0, POOL_PAIRS - 1);
        it.opcode       = OP_QUERY;
        it.subject_key  = {$urandom, $urandom};
        it.issuer_key   = {$urandom, $urandom};
        it.subject_type = 4'($urandom_range(0, 15));
        it.flush_all    = 1'($urandom);
        it.signature_ok = 1'($urandom);
        if (pick < 4) begin
            it.opcode    = OP_FLUSH;
            it.flush_all = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) != 0) it.subject_type = 4'($urandom_range(0, 3));
        end else if (pick < 88) begin
            it.subject_key  = pool_subject[k];
            it.issuer_key   = pool_issuer[k];
            it.subject_type = pool_type[k];
            it.signature_ok = ($urandom_range(0, 4) != 0);
        end else if (pick < 94) begin
            // known subject under an unknown issuer
            it.subject_key = pool_subject[k];
        end
        return it;
    endfunction

    task automatic push_item(input logic op, input logic [FIELD_KEY_BITS-1:0] skey,
                             input logic [FIELD_KEY_BITS-1:0] ikey, input logic [3:0] stype,
                             input logic all, input logic sig);
        t_item it;
        it.opcode       = op;
        it.subject_key  = skey;
        it.issuer_key   = ikey;
        it.subject_type = stype;
        it.flush_all    = all;
        it.signature_ok = sig;
        pending_items.push_back(it);
    endtask

    // Hold until every item is sent and every result has come back
    task automatic wait_idle();
        do @(negedge clk);
        while (pending_items.size() != 0 || item_ch.valid || expected_results.size() != 0);
    endtask

    task automatic write_limit(input logic [CFG_BITS-1:0] value);
        @(posedge clk);
        cfg_ch.data  <= value;
        cfg_ch.valid <= 1'b1;
        do @(posedge clk);
        while (!cfg_ch.ready);
        limit_shadow = value;
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] seen);
        if (seen !== want) begin
            error_count++;
            // keep the log short when the block is badly broken
            if (error_count <= REPORT_CAP)
                $error("%s: expected %0d, got %0d", name, want, seen);
        end
    endtask

    // Driver: offer pending items with random gaps between them
    always @(posedge clk) begin
        if (!rst_n) begin
            item_ch.valid <= 1'b0;
            item_ch.data  <= '0;
            send_gap      <= 0;
        end else begin
            if (item_ch.valid && item_ch.ready)
                expected_results.push_back(predict_lookup(item_ch.data));
            if (!item_ch.valid || item_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap      <= send_gap - 1;
                    item_ch.valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    item_ch.data  <= pending_items.pop_front();
                    item_ch.valid <= 1'b1;
                    send_gap      <= send_gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
                end else begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result item and stall the result channel
    always @(posedge clk) begin : result_monitor
        logic    got;
        int      draw;
        t_result want;
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
            stall_left   <= 0;
            hold_left    <= 0;
        end else begin
            got = res_ch.valid && res_ch.ready;
            if (got) begin
                if (expected_results.size() == 0) begin
                    error_count++;
                    $error("result item with no query outstanding");
                end else begin
                    want = expected_results.pop_front();
                    check_field("trusted", want.trusted, res_ch.data.trusted);
                    check_field("cache_hit", want.cache_hit, res_ch.data.cache_hit);
                    check_field("evicted", want.evicted, res_ch.data.evicted);
                    check_field("entries_used", want.entries_used, res_ch.data.entries_used);
                    check_field("flushed_count", want.flushed_count,
                                res_ch.data.flushed_count);
                end
                results_checked++;
            end
            if (hold_left > 0) begin
                hold_left    <= hold_left - 1;
                res_ch.ready <= 1'b0;
            end else if (got && (results_checked == 200 || results_checked == 600)) begin
                // long hold-off so the sender backs up behind a full block
                hold_left    <= HOLD_CYCLES;
                res_ch.ready <= 1'b0;
            end else if (got) begin
                draw = recv_stalls_on ? $urandom_range(0, MAX_WAIT) : 0;
                stall_left   <= draw;
                res_ch.ready <= (draw == 0);
            end else if (stall_left > 0) begin
                // count the stall only while a result item is waiting
                if (res_ch.valid) begin
                    stall_left   <= stall_left - 1;
                    res_ch.ready <= (stall_left == 1);
                end
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk) begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [FIELD_KEY_BITS-1:0] ones;
        logic [CFG_BITS-1:0]       lim;
        ones = '1;
        rst_n         <= 1'b0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.data   <= '0;
        for (int i = 0; i < SLOTS; i++) held_valid[i] = 1'b0;
        use_clock    = '0;
        limit_shadow = LIMIT_RESET;

        // Pairs share subjects so that issuer mismatches occur too
        for (int i = 0; i < POOL_PAIRS; i++) begin
            pool_issuer[i] = {$urandom, $urandom};
            pool_type[i]   = 4'($urandom_range(0, 3));
        end
        for (int i = 0; i < POOL_PAIRS; i++)
            pool_subject[i] = (i < POOL_SUBJECTS) ? {$urandom, $urandom} :
                              pool_subject[i % POOL_SUBJECTS];

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Extreme keys, hits, misses and flushes at the reset limit
        push_item(OP_QUERY, '0, '0, 4'd0, 1'b0, 1'b0);
        push_item(OP_QUERY, '0, '0, 4'd0, 1'b0, 1'b1);
        push_item(OP_QUERY, '0, '0, 4'd0, 1'b0, 1'b0);
        push_item(OP_QUERY, ones, ones, 4'd15, 1'b1, 1'b1);
        push_item(OP_QUERY, ones, ones, 4'd15, 1'b0, 1'b0);
        push_item(OP_QUERY, ones, '0, 4'd15, 1'b0, 1'b0);
        push_item(OP_QUERY, '0, ones, 4'd5, 1'b0, 1'b1);
        push_item(OP_FLUSH, ones, ones, 4'd9, 1'b0, 1'b1);
        push_item(OP_FLUSH, '0, '0, 4'd15, 1'b0, 1'b0);
        push_item(OP_FLUSH, '0, '0, 4'd0, 1'b1, 1'b0);
        push_item(OP_FLUSH, ones, ones, 4'd15, 1'b1, 1'b1);
        wait_idle();

        // Small limit: the least recently used pair goes, not the newest
        write_limit(6'd2);
        push_item(OP_QUERY, 64'd1, 64'd2, 4'd1, 1'b0, 1'b1);
        push_item(OP_QUERY, 64'd3, 64'd4, 4'd2, 1'b0, 1'b1);
        push_item(OP_QUERY, 64'd1, 64'd2, 4'd1, 1'b0, 1'b0);
        push_item(OP_QUERY, 64'd5, 64'd6, 4'd1, 1'b0, 1'b1);
        push_item(OP_QUERY, 64'd3, 64'd4, 4'd2, 1'b0, 1'b0);
        push_item(OP_QUERY, 64'd1, 64'd2, 4'd1, 1'b0, 1'b0);
        wait_idle();

        // Zero limit acts as one; lowering it forces several evictions
        write_limit(6'd0);
        push_item(OP_QUERY, 64'd7, 64'd8, 4'd1, 1'b0, 1'b1);
        push_item(OP_QUERY, 64'd7, 64'd8, 4'd1, 1'b0, 1'b0);
        push_item(OP_QUERY, 64'd9, 64'd10, 4'd1, 1'b0, 1'b1);
        push_item(OP_FLUSH, '0, '0, 4'd1, 1'b0, 1'b0);

        // Random phases under a spread of limits, the extremes among them
        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            case (p)
                0: lim = 6'd63;
                1: lim = 6'd3;
                2: lim = 6'd32;
                3: lim = 6'd1;
                4: lim = 6'd0;
                6: lim = 6'd32;
                default: lim = CFG_BITS'($urandom_range(0, 63));
            endcase
            write_limit(lim);
            send_gaps_on   = (p % 3 != 2);
            recv_stalls_on = (p % 3 != 1);
            repeat (PHASE_ITEMS) pending_items.push_back(random_item());
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== verified_pair_lru_cache_unit.f =====
rtl/vplc_pkg.sv
rtl/vplc_ifs.sv
rtl/verified_pair_lru_cache_unit.sv
tb/sv/tb.sv
